// ===== hdl/tmeu_pkg.sv =====
// ============================================================================
// tmeu_pkg
// Shared types, command codes and default sizes for the tape machine
// execute unit.
// ============================================================================
package tmeu_pkg;

    localparam int TAPE_DEPTH_DEF    = 65536;
    localparam int PROGRAM_DEPTH_DEF = 65536;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_MOVE   = 3'd1;
    localparam logic [2:0] CMD_OUT    = 3'd2;
    localparam logic [2:0] CMD_IN     = 3'd3;
    localparam logic [2:0] CMD_JZ     = 3'd4;
    localparam logic [2:0] CMD_JNZ    = 3'd5;
    localparam logic [2:0] CMD_CLEAR  = 3'd6;
    localparam logic [2:0] CMD_MULADD = 3'd7;

    typedef struct packed {
        logic [2:0]         command;
        logic [15:0]        pc_now;
        logic signed [31:0] arg_first;
        logic signed [15:0] arg_factor;
        logic [7:0]         in_byte;
        logic               in_eof;
    } cmd_item_t;

    typedef struct packed {
        logic [16:0] next_pc;
        logic        out_valid;
        logic [7:0]  out_byte;
    } res_item_t;

    // classified operation handed from the front end to the back end
    typedef struct packed {
        logic [2:0]  cmd;
        logic [16:0] pc_plus;
        logic [16:0] target;
        logic [7:0]  data;
        logic [7:0]  delta;
        logic [7:0]  factor;
    } op_t;

endpackage

// ===== hdl/tmeu_ram.sv =====
// ============================================================================
// tmeu_ram
// Generic RAM: one write port, two read ports with registered read data.
// ============================================================================
module tmeu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ===== hdl/tmeu_cmod.sv =====
// ============================================================================
// tmeu_cmod
// Three-stage remainder of a 32-bit unsigned value by a constant divisor:
// reciprocal multiply, quotient times divisor, then one correction step.
// ============================================================================
module tmeu_cmod #(
    parameter int DIVISOR = 64,
    localparam int RW     = $clog2(DIVISOR)
) (
    input  logic          clk,
    input  logic          en,
    input  logic [31:0]   x,
    output logic [RW-1:0] rem
);

    localparam int          SH    = 32 + RW;
    localparam logic [63:0] MUL_W = (64'd1 << SH) / 64'(DIVISOR);
    localparam logic [32:0] MUL   = MUL_W[32:0];
    localparam logic [31:0] DIV32 = 32'(DIVISOR);

    logic [64:0] prod_reg;
    logic [64:0] prod_next;
    logic [31:0] x1_reg;
    logic [31:0] x2_reg;
    logic [31:0] qd_reg;
    logic [31:0] qd_next;
    logic [RW-1:0] rem_reg;
    logic [RW-1:0] rem_next;
    logic [64:0] q_shift;
    logic [63:0] qd_full;
    logic [31:0] diff;
    logic [31:0] diff_fix;

    always_comb
    begin
        prod_next = 65'(x) * 65'(MUL);
        q_shift   = prod_reg >> SH;
        qd_full   = 64'(q_shift[31:0]) * 64'(DIV32);
        qd_next   = qd_full[31:0];
        diff      = x2_reg - qd_reg;
        diff_fix  = (diff >= DIV32) ? (diff - DIV32) : diff;
        rem_next  = diff_fix[RW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            x1_reg   <= x;
            qd_reg   <= qd_next;
            x2_reg   <= x1_reg;
            rem_reg  <= rem_next;
        end
    end

    assign rem = rem_reg;

endmodule

// ===== hdl/tmeu_front.sv =====
// ============================================================================
// tmeu_front
// Front end: accepts transactions, reduces the offset and jump target by the
// tape and program depths, and pushes classified operations into the queue.
// ============================================================================
module tmeu_front #(
    parameter int TAPE_DEPTH    = tmeu_pkg::TAPE_DEPTH_DEF,
    parameter int PROGRAM_DEPTH = tmeu_pkg::PROGRAM_DEPTH_DEF,
    localparam int TAW          = $clog2(TAPE_DEPTH),
    localparam int PAW          = $clog2(PROGRAM_DEPTH)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                hold,
    input  logic                item_valid,
    output logic                item_stall,
    input  tmeu_pkg::cmd_item_t item,
    input  logic                q_full,
    output logic                q_push,
    output tmeu_pkg::op_t       q_op,
    output logic [TAW-1:0]      q_off
);

    import tmeu_pkg::*;

    // 2^32 mod depth, the correction for a negative offset
    localparam logic [63:0]    WRAP_K  = (64'd1 << 32) % 64'(TAPE_DEPTH);
    localparam logic [TAW-1:0] WK      = TAW'(WRAP_K);
    localparam logic [TAW-1:0] WK_COMP = TAW'(64'(TAPE_DEPTH) - WRAP_K);

    logic      adv;
    logic      accept;
    logic      v1_reg;
    logic      v2_reg;
    logic      v3_reg;
    cmd_item_t p1_reg;
    cmd_item_t p2_reg;
    cmd_item_t p3_reg;
    logic [TAW-1:0] tape_rem;
    logic [PAW-1:0] prog_rem;
    logic [31:0]    target_w;

    assign adv        = !(v3_reg && q_full);
    assign item_stall = hold || !adv;
    assign accept     = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg <= item;
            p2_reg <= p1_reg;
            p3_reg <= p2_reg;
        end
    end

    tmeu_cmod #(.DIVISOR(TAPE_DEPTH)) u_tape_mod (
        .clk (clk),
        .en  (adv),
        .x   ($unsigned(item.arg_first)),
        .rem (tape_rem)
    );

    tmeu_cmod #(.DIVISOR(PROGRAM_DEPTH)) u_prog_mod (
        .clk (clk),
        .en  (adv),
        .x   ($unsigned(item.arg_first)),
        .rem (prog_rem)
    );

    always_comb
    begin
        target_w       = 32'(prog_rem) + 32'd1;
        q_op.cmd       = p3_reg.command;
        q_op.pc_plus   = {1'b0, p3_reg.pc_now} + 17'd1;
        q_op.target    = target_w[16:0];
        q_op.data      = p3_reg.in_eof ? 8'd0 : p3_reg.in_byte;
        q_op.delta     = p3_reg.arg_first[7:0];
        q_op.factor    = p3_reg.arg_factor[7:0];
        if (!p3_reg.arg_first[31])
        begin
            q_off = tape_rem;
        end
        else if (tape_rem >= WK)
        begin
            q_off = tape_rem - WK;
        end
        else
        begin
            q_off = tape_rem + WK_COMP;
        end
    end

    assign q_push = v3_reg && !q_full;

endmodule

// ===== hdl/tmeu_fifo.sv =====
// ============================================================================
// tmeu_fifo
// Small register queue between the front and back ends.
// ============================================================================
module tmeu_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);
    localparam logic [PW:0]   DEPTH_C = (PW + 1)'(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW:0]      count_reg;
    logic [PW:0]      count_next;

    assign full  = (count_reg == DEPTH_C);
    assign empty = (count_reg == '0);
    assign dout  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== hdl/tmeu_back.sv =====
// ============================================================================
// tmeu_back
// Back end: clears the tape after reset, then reads the head and target cells
// of an operation in ST_ISSUE, then writes and forms the result in ST_EXEC.
// ============================================================================
module tmeu_back #(
    parameter int TAPE_DEPTH = tmeu_pkg::TAPE_DEPTH_DEF,
    localparam int TAW       = $clog2(TAPE_DEPTH)
) (
    input  logic                clk,
    input  logic                rst_n,
    output logic                clearing,
    input  logic                q_empty,
    input  tmeu_pkg::op_t       q_op,
    input  logic [TAW-1:0]      q_off,
    output logic                q_pop,
    output logic                res_valid,
    input  logic                res_stall,
    output tmeu_pkg::res_item_t res_item
);

    import tmeu_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    localparam logic [TAW-1:0] LAST    = TAW'(TAPE_DEPTH - 1);
    localparam logic [TAW:0]   DEPTH_X = (TAW + 1)'(TAPE_DEPTH);

    logic [1:0]     state_reg;
    logic [1:0]     state_next;
    logic [TAW-1:0] clr_addr_reg;
    logic [TAW-1:0] clr_addr_next;
    logic [TAW-1:0] head_reg;
    logic [TAW-1:0] head_next;
    logic [TAW-1:0] idx_reg;
    logic [TAW-1:0] idx_next;
    logic [TAW:0]   idx_sum;
    op_t            op_reg;
    logic           res_valid_reg;
    res_item_t      res_reg;
    res_item_t      res_next;
    logic           load_res;
    logic           slot_free;
    logic           cur_zero;
    logic [15:0]    prod;

    logic           we;
    logic [TAW-1:0] waddr;
    logic [7:0]     wdata;
    logic           re;
    logic [7:0]     cur;
    logic [7:0]     tgt;

    tmeu_ram #(.WIDTH(8), .DEPTH(TAPE_DEPTH)) u_tape (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .re      (re),
        .raddr_a (head_reg),
        .raddr_b (idx_next),
        .rdata_a (cur),
        .rdata_b (tgt)
    );

    always_comb
    begin
        idx_sum  = {1'b0, head_reg} + {1'b0, q_off};
        if (idx_sum >= DEPTH_X)
        begin
            idx_sum = idx_sum - DEPTH_X;
        end
        idx_next = idx_sum[TAW-1:0];
    end

    assign slot_free = !res_valid_reg || !res_stall;
    assign cur_zero  = (cur == 8'd0);
    assign prod      = 16'(cur) * 16'(op_reg.factor);

    always_comb
    begin
        res_next.next_pc   = op_reg.pc_plus;
        res_next.out_valid = 1'b0;
        res_next.out_byte  = 8'd0;
        if ((op_reg.cmd == CMD_JZ && cur_zero) || (op_reg.cmd == CMD_JNZ && !cur_zero))
        begin
            res_next.next_pc = op_reg.target;
        end
        if (op_reg.cmd == CMD_OUT)
        begin
            res_next.out_valid = 1'b1;
            res_next.out_byte  = cur;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        head_next     = head_reg;
        we            = 1'b0;
        waddr         = head_reg;
        wdata         = 8'd0;
        re            = 1'b0;
        q_pop         = 1'b0;
        load_res      = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                we            = 1'b1;
                waddr         = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    re         = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (slot_free)
                begin
                    load_res   = 1'b1;
                    state_next = ST_ISSUE;
                    unique case (op_reg.cmd) inside
                        CMD_ADD:
                        begin
                            we    = 1'b1;
                            wdata = cur + op_reg.delta;
                        end
                        CMD_MOVE:
                        begin
                            head_next = idx_reg;
                        end
                        CMD_IN:
                        begin
                            we    = 1'b1;
                            wdata = op_reg.data;
                        end
                        CMD_CLEAR:
                        begin
                            we = 1'b1;
                        end
                        CMD_MULADD:
                        begin
                            we    = !cur_zero;
                            waddr = idx_reg;
                            wdata = tgt + prod[7:0];
                        end
                        CMD_OUT, CMD_JZ, CMD_JNZ:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_ISSUE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            head_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            head_reg     <= head_next;
            if (load_res)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            op_reg  <= q_op;
            idx_reg <= idx_next;
        end
        if (load_res)
        begin
            res_reg <= res_next;
        end
    end

    assign clearing  = (state_reg == ST_CLEAR);
    assign res_valid = res_valid_reg;
    assign res_item  = res_reg;

endmodule

// ===== hdl/tape_machine_execute_unit.sv =====
// ============================================================================
// tape_machine_execute_unit
// Execute stage of a byte-tape machine with clear and multiply-add.
// ============================================================================
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd_item) takes one decoded
//   operation per transaction; res channel (res_valid / res_stall / res_item)
//   returns exactly one result per operation, in order.
//   An accepted command passes the three front-end stages, the queue, and
//   the back end's ST_ISSUE and ST_EXEC states before res_valid rises.
//   The back end sets the pace: it takes a new operation only once the last
//   is through, reading the head and target cells in ST_ISSUE and writing
//   the tape in ST_EXEC through the single write port of the tape RAM.
//   The front end reduces offsets and jump targets in a 3-stage pipeline and
//   feeds a 4-entry queue, so commands are taken every cycle until it fills.
//   Reset: the tape RAM is cleared one cell per cycle, all TAPE_DEPTH cells,
//   with cmd_stall high; the head returns to cell 0.
//   A stalled result holds in the output register; the back end keeps one
//   operation in flight and the queue and front pipeline fill behind it
//   before cmd_stall rises.
// ============================================================================
module tape_machine_execute_unit #(
    parameter int TAPE_DEPTH    = tmeu_pkg::TAPE_DEPTH_DEF,
    parameter int PROGRAM_DEPTH = tmeu_pkg::PROGRAM_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  tmeu_pkg::cmd_item_t cmd_item,
    output logic                res_valid,
    input  logic                res_stall,
    output tmeu_pkg::res_item_t res_item
);

    import tmeu_pkg::*;

    localparam int TAW = $clog2(TAPE_DEPTH);
    localparam int QW  = $bits(op_t) + TAW;

    logic           hold;
    logic           q_full;
    logic           q_push;
    op_t            f_op;
    logic [TAW-1:0] f_off;
    logic           q_empty;
    logic           q_pop;
    logic [QW-1:0]  q_dout;
    op_t            b_op;
    logic [TAW-1:0] b_off;

    tmeu_front #(
        .TAPE_DEPTH    (TAPE_DEPTH),
        .PROGRAM_DEPTH (PROGRAM_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .hold       (hold),
        .item_valid (cmd_valid),
        .item_stall (cmd_stall),
        .item       (cmd_item),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_op       (f_op),
        .q_off      (f_off)
    );

    tmeu_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   ({f_off, f_op}),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty)
    );

    assign b_op  = q_dout[$bits(op_t)-1:0];
    assign b_off = q_dout[QW-1:$bits(op_t)];

    tmeu_back #(
        .TAPE_DEPTH (TAPE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .clearing  (hold),
        .q_empty   (q_empty),
        .q_op      (b_op),
        .q_off     (b_off),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

endmodule

// ===== hdl/tmeu_checker.sv =====
// ============================================================================
// tmeu_checker
// Port-level checks on the execute unit, bound to the top level.
// ============================================================================
module tmeu_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_stall,
    input logic                res_valid,
    input logic                res_stall,
    input tmeu_pkg::res_item_t res_item
);

    import tmeu_pkg::*;

    // stalled result transaction holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_item))
        else $error("result changed while stalled");

    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_item.out_valid |-> res_item.out_byte == 8'd0)
        else $error("output byte set on a non-output result");

    a_pc_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_item.next_pc != 17'd0)
        else $error("next pc of zero");

    // tape clear pass starts right after reset
    a_clear_stall: assert property (@(posedge clk)
        rst_n && !$past(rst_n) |-> cmd_stall && !res_valid)
        else $error("commands taken during tape clear");

endmodule

bind tape_machine_execute_unit tmeu_checker u_tmeu_checker (.*);

// ===== dv/tb_top.sv =====
// ============================================================================
// tb_top
// Self-checking testbench for tape_machine_execute_unit. Operations are sent
// on the command channel. Each accepted operation is run through a local
// model of the byte tape and head, and the model's result is queued. Every
// result that comes back is compared field by field with the oldest queued
// result. A short directed pass covers arithmetic wrap, end of input, jumps
// at the program counter limits, head wrap, and multiply-add corner cases.
// Random traffic then runs under four flow-control settings.
// ============================================================================
module tb_top;

    import tmeu_pkg::*;

    localparam int MAX_PRINTED = 40;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_stall;
    cmd_item_t cmd_item;
    logic      res_valid;
    logic      res_stall;
    res_item_t res_item;

    logic [7:0]  tape_model [0:TAPE_DEPTH_DEF-1];
    logic [15:0] head_model;
    res_item_t   expected_q[$];

    int send_idle_pct;
    int recv_stall_pct;
    int error_count;
    int ops_sent;
    int results_checked;

    tape_machine_execute_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("tb_top: timeout");
        $display("tb_top: done, errors");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTED)
            $display("tb_top: ERROR: %s", msg);
        error_count++;
    endtask

    // model of one operation on the tape; returns the result it should produce
    function automatic res_item_t predict_op(input cmd_item_t op);
        logic [7:0]  cur;
        logic [15:0] idx;
        logic [15:0] prod;
        res_item_t   res;
        cur           = tape_model[head_model];
        res.next_pc   = {1'b0, op.pc_now} + 17'd1;
        res.out_valid = 1'b0;
        res.out_byte  = 8'd0;
        case (op.command)
            CMD_ADD:
                tape_model[head_model] = cur + op.arg_first[7:0];
            CMD_MOVE:
                head_model = head_model + op.arg_first[15:0];
            CMD_OUT:
            begin
                res.out_valid = 1'b1;
                res.out_byte  = cur;
            end
            CMD_IN:
                tape_model[head_model] = op.in_eof ? 8'd0 : op.in_byte;
            CMD_JZ:
                if (cur == 8'd0)
                    res.next_pc = {1'b0, op.arg_first[15:0]} + 17'd1;
            CMD_JNZ:
                if (cur != 8'd0)
                    res.next_pc = {1'b0, op.arg_first[15:0]} + 17'd1;
            CMD_CLEAR:
                tape_model[head_model] = 8'd0;
            CMD_MULADD:
                if (cur != 8'd0)
                begin
                    idx  = head_model + op.arg_first[15:0];
                    prod = {8'd0, cur} * {8'd0, op.arg_factor[7:0]};
                    tape_model[idx] = tape_model[idx] + prod[7:0];
                end
            default:
                ;
        endcase
        return res;
    endfunction

    function automatic cmd_item_t make_op(input logic [2:0] cmd, input logic [15:0] pc,
                                          input logic [31:0] a, input logic [15:0] f,
                                          input logic [7:0] b, input logic eof);
        cmd_item_t op;
        op.command    = cmd;
        op.pc_now     = pc;
        op.arg_first  = a;
        op.arg_factor = f;
        op.in_byte    = b;
        op.in_eof     = eof;
        return op;
    endfunction

    task automatic send_op(input cmd_item_t op);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_item  <= op;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        expected_q.push_back(predict_op(op));
        ops_sent++;
    endtask

    // result checker and receiver-side stall
    initial
    begin
        res_item_t exp_res;
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
            begin
                if (expected_q.size() == 0)
                    report_mismatch($sformatf("unexpected result %h", res_item));
                else
                begin
                    exp_res = expected_q.pop_front();
                    results_checked++;
                    if (res_item.next_pc !== exp_res.next_pc)
                        report_mismatch($sformatf("next_pc %h, expected %h",
                                                  res_item.next_pc, exp_res.next_pc));
                    if (res_item.out_valid !== exp_res.out_valid)
                        report_mismatch($sformatf("out_valid %b, expected %b",
                                                  res_item.out_valid, exp_res.out_valid));
                    if (res_item.out_byte !== exp_res.out_byte)
                        report_mismatch($sformatf("out_byte %h, expected %h",
                                                  res_item.out_byte, exp_res.out_byte));
                end
            end
            res_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic test_data_ops();
        send_op(make_op(CMD_OUT,   16'h0000, 32'h0000_0000, 16'h0000, 8'h00, 1'b0));
        send_op(make_op(CMD_ADD,   16'h0001, 32'h0000_0001, 16'h0000, 8'h00, 1'b0));
        send_op(make_op(CMD_OUT,   16'h0002, 32'h0000_0000, 16'h0000, 8'h00, 1'b0));
        send_op(make_op(CMD_ADD,   16'h0003, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 1'b0));
        send_op(make_op(CMD_ADD,   16'h0004, 32'h7FFF_FFFF, 16'h0000, 8'h00, 1'b0));
        send_op(make_op(CMD_ADD,   16'h0005, 32'h8000_0000, 16'h0000, 8'h00, 1'b0));
        send_op(make_op(CMD_OUT,   16'h0006, 32'h0000_0000, 16'h0000, 8'h00, 1'b0));
        send_op(make_op(CMD_IN,    16'h0007, 32'h0000_0000, 16'h0000, 8'hA5, 1'b0));
        send_op(make_op(CMD_OUT,   16'h0008, 32'h0000_0000, 16'h0000, 8'h00, 1'b0));
        send_op(make_op(CMD_IN,    16'h0009, 32'h0000_0000, 16'h0000, 8'hFF, 1'b1));
        send_op(make_op(CMD_OUT,   16'h000A, 32'h0000_0000, 16'h0000, 8'h00, 1'b0));
    endtask

    task automatic test_jumps();
        send_op(make_op(CMD_JZ,    16'hFFFF, 32'hFFFF_FFFF, 16'h0000, 8'h00, 1'b0));
        send_op(make_op(CMD_JNZ,   16'hFFFF, 32'h0000_0010, 16'h0000, 8'h00, 1'b0));
        send_op(make_op(CMD_ADD,   16'h0010, 32'h0000_0003, 16'h0000, 8'h00, 1'b0));
        send_op(make_op(CMD_JNZ,   16'h0011, 32'h1234_5678, 16'h0000, 8'h00, 1'b0));
        send_op(make_op(CMD_JZ,    16'h0012, 32'h0000_0000, 16'h0000, 8'h00, 1'b0));
        send_op(make_op(CMD_CLEAR, 16'h0013, 32'h0000_0000, 16'h0000, 8'h00, 1'b0));
        send_op(make_op(CMD_OUT,   16'h0014, 32'h0000_0000, 16'h0000, 8'h00, 1'b0));
    endtask

    task automatic test_head_and_muladd();
        // head wraps below cell 0, then multiply-add reaches back across the wrap
        send_op(make_op(CMD_MOVE,   16'h0020, 32'hFFFF_FFFF, 16'h0000, 8'h00, 1'b0));
        send_op(make_op(CMD_ADD,    16'h0021, 32'h0000_0002, 16'h0000, 8'h00, 1'b0));
        send_op(make_op(CMD_MULADD, 16'h0022, 32'h0000_0001, 16'h8003, 8'h00, 1'b0));
        send_op(make_op(CMD_MULADD, 16'h0023, 32'h0000_0000, 16'hFFFF, 8'h00, 1'b0));
        send_op(make_op(CMD_MULADD, 16'h0024, 32'h0000_0001, 16'h0005, 8'h00, 1'b0));
        send_op(make_op(CMD_MOVE,   16'h0025, 32'h0001_0001, 16'h0000, 8'h00, 1'b0));
        send_op(make_op(CMD_OUT,    16'h0026, 32'h0000_0000, 16'h0000, 8'h00, 1'b0));
    endtask

    function automatic cmd_item_t random_op();
        cmd_item_t op;
        op.command    = 3'($urandom_range(7));
        op.pc_now     = 16'($urandom);
        // mostly short moves and offsets so the head stays among written cells
        if ($urandom_range(9) < 7)
            op.arg_first = 32'($urandom_range(8)) - 32'd4;
        else
            op.arg_first = 32'($urandom);
        op.arg_factor = 16'($urandom);
        op.in_byte    = 8'($urandom);
        op.in_eof     = ($urandom_range(7) == 0);
        return op;
    endfunction

    task automatic test_random_traffic(input int count, input int send_pct,
                                       input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count)
            send_op(random_op());
    endtask

    initial
    begin
        cmd_valid      <= 1'b0;
        cmd_item       <= '0;
        rst_n          <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        error_count    = 0;
        ops_sent       = 0;
        results_checked = 0;
        head_model     = 16'd0;
        foreach (tape_model[i])
            tape_model[i] = 8'd0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_data_ops();
        test_jumps();
        test_head_and_muladd();
        test_random_traffic(412, 0, 0);
        test_random_traffic(412, 52, 0);
        test_random_traffic(412, 0, 52);
        test_random_traffic(412, 27, 27);
        cmd_valid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("tb_top: %0d operations sent, %0d results checked", ops_sent,
                 results_checked);
        $display("tb_top: directed corners plus random traffic under four stall mixes");
        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
